/* hdl/ksc_pkg.sv */
// Shared types, codes and helpers for the keyword substitution cipher.
// No dependencies; imported by ksc_ctrl, ksc_datapath and the top level.
package ksc_pkg;

  localparam int ALPHA_LEN = 26;
  localparam int IDX_W     = 5;

  typedef logic [IDX_W-1:0] idx_t;

  typedef enum logic [1:0] {
    FN_CLEAR = 2'd0,
    FN_KEY   = 2'd1,
    FN_ENC   = 2'd2,
    FN_DEC   = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_READ,
    ST_EMIT
  } state_t;

  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_Z  = 8'h5a;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_Z  = 8'h7a;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam idx_t LAST_IDX = idx_t'(ALPHA_LEN - 1);
  localparam idx_t FULL_CNT = idx_t'(ALPHA_LEN);

  typedef struct packed {
    logic valid;
    idx_t idx;
  } letter_t;

  // controller -> datapath
  typedef struct packed {
    logic clear;
    logic key;
    logic latch;
    logic walk;
    logic emit;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic done;
    logic walk_last;
    logic out_free;
  } stat_t;

  // case-folded letter index of an ASCII byte
  function automatic letter_t letter_of(input logic [7:0] ch);
    letter_t    r;
    logic [7:0] diff;
    r.valid = 1'b0;
    diff    = '0;
    if (ch inside {[CH_UP_A:CH_UP_Z]}) begin
      r.valid = 1'b1;
      diff    = ch - CH_UP_A;
    end else if (ch inside {[CH_LO_A:CH_LO_Z]}) begin
      r.valid = 1'b1;
      diff    = ch - CH_LO_A;
    end
    r.idx = diff[IDX_W-1:0];
    return r;
  endfunction

endpackage

/* hdl/ksc_ctrl.sv */
// Sequencer for the keyword substitution cipher.
// Depends on ksc_pkg; drives ksc_datapath through cmd_t, reads stat_t.
module ksc_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [1:0]      func,
  input  ksc_pkg::stat_t  stat,
  output ksc_pkg::cmd_t   cmd
);
  import ksc_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (func)
            FN_CLEAR: cmd.clear = 1'b1;
            FN_KEY:   cmd.key   = 1'b1;
            default: begin
              cmd.latch  = 1'b1;
              state_next = stat.done ? ST_READ : ST_WALK;
            end
          endcase
        end
      end
      ST_WALK: begin
        cmd.walk = 1'b1;
        if (stat.walk_last) begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

/* hdl/ksc_datapath.sv */
// Tables, letter bookkeeping and output register of the cipher.
// Depends on ksc_pkg; sequenced by ksc_ctrl.
module ksc_datapath (
  input  logic            clk,
  input  logic            rst,
  input  ksc_pkg::cmd_t   cmd,
  output ksc_pkg::stat_t  stat,
  input  logic [1:0]      func,
  input  logic [7:0]      char_in,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [7:0]      char_out
);
  import ksc_pkg::*;

  idx_t                 fwd_mem [ALPHA_LEN];
  idx_t                 inv_mem [ALPHA_LEN];
  logic [ALPHA_LEN-1:0] used;
  idx_t                 fill;
  logic                 done;
  idx_t                 walk_idx;
  logic [7:0]           msg_char;
  logic                 msg_dec;
  idx_t                 rd_fwd;
  idx_t                 rd_inv;

  letter_t in_let;
  letter_t msg_let;
  logic    key_wr;
  logic    walk_wr;
  logic    tbl_we;
  idx_t    new_letter;
  idx_t    rd_addr;
  idx_t    rd_val;

  assign in_let  = letter_of(char_in);
  assign msg_let = letter_of(msg_char);

  assign key_wr  = cmd.key && !done && in_let.valid && !used[in_let.idx] && (fill < FULL_CNT);
  assign walk_wr = cmd.walk && !used[walk_idx] && (fill < FULL_CNT);
  assign tbl_we  = key_wr || walk_wr;
  assign new_letter = cmd.walk ? walk_idx : in_let.idx;

  assign rd_addr = msg_let.valid ? msg_let.idx : '0;
  assign rd_val  = msg_dec ? rd_inv : rd_fwd;

  assign stat.done      = done;
  assign stat.walk_last = (walk_idx == LAST_IDX);
  assign stat.out_free  = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (tbl_we) begin
      fwd_mem[fill]       <= new_letter;
      inv_mem[new_letter] <= fill;
    end
    rd_fwd <= fwd_mem[rd_addr];
    rd_inv <= inv_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
      fill <= '0;
      done <= 1'b0;
    end else begin
      if (cmd.clear) begin
        used <= '0;
        fill <= '0;
        done <= 1'b0;
      end else begin
        if (tbl_we) begin
          used[new_letter] <= 1'b1;
          fill             <= fill + idx_t'(1);
        end
        if (cmd.walk && stat.walk_last) begin
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      msg_char <= char_in;
      msg_dec  <= (func == FN_DEC);
      walk_idx <= '0;
    end else if (cmd.walk) begin
      walk_idx <= walk_idx + idx_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit && (msg_char == CH_SPACE || msg_let.valid)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      char_out <= (msg_char == CH_SPACE) ? CH_SPACE : CH_LO_A + {3'b000, rd_val};
    end
  end

`ifndef SYNTHESIS
  a_fill_range: assert property (@(posedge clk) disable iff (rst) fill <= FULL_CNT)
    else $error("fill count beyond alphabet");
  a_used_count: assert property (@(posedge clk) disable iff (rst)
    $countones(used) == int'(fill))
    else $error("used letters disagree with fill count");
  a_done_full: assert property (@(posedge clk) disable iff (rst) done |-> fill == FULL_CNT)
    else $error("table marked done while not full");
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!out_valid || out_ready))
    else $error("emit into an occupied output register");
`endif

endmodule

/* hdl/keyword_substitution_cipher.sv */
// Top level of the keyword substitution cipher.
// Depends on ksc_pkg, ksc_ctrl and ksc_datapath.
//
//  channel | dir | handshake           | payload
//  --------+-----+---------------------+-----------------------------
//  in      | in  | in_valid / in_ready | func[1:0], char_in[7:0]
//  out     | out | out_valid/out_ready | char_out[7:0]
//
// Clear and key beats complete in the idle state. A message beat passes read
// and emit, waiting in emit for a free output slot; the first message beat
// after a clear or reset first walks the 26 letters through the table write port.
// The output register lets a new input beat be taken while a result waits.
// Reset (rst, synchronous) empties the key and the output register; table
// contents stay undefined until written by a key or by the walk.
module keyword_substitution_cipher (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] func,
  input  logic [7:0] char_in,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] char_out
);
  import ksc_pkg::*;

  // command and status between sequencer and datapath
  cmd_t  cmd;
  stat_t stat;

  // sequencer: accepts beats, runs the alphabet walk, schedules lookups
  ksc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .func     (func),
    .stat     (stat),
    .cmd      (cmd)
  );

  // datapath: forward/inverse tables, used-letter mask, output register
  ksc_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .func      (func),
    .char_in   (char_in),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .char_out  (char_out)
  );

endmodule
